@@ design/rtgf_pkg.sv @@
// Shared types, constants and helper functions of the radar track gate and fuse block.
// No dependencies; rtgf_cfg_if and radar_track_gate_fuse import this package.
package rtgf_pkg;

	localparam int TABLE_DEPTH   = 32;
	localparam int IDX_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_INDEX_W = 5;
	localparam int GATE_W        = 16;
	localparam int GATE_SQ_W     = 2 * GATE_W;
	localparam int CFG_IDX_W     = 2;

	localparam logic [1:0] OP_CLEAR     = 2'd0;
	localparam logic [1:0] OP_LOAD      = 2'd1;
	localparam logic [1:0] OP_ASSOCIATE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_GATE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_GATE = 2'd1;

	localparam logic [GATE_W-1:0] RANGE_GATE_RST    = 16'd32;
	localparam logic [GATE_W-1:0] VELOCITY_GATE_RST = 16'd64;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic [7:0]         road;
		logic [15:0]        id;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Floor of the halved sum of two signed coordinates.
	function automatic logic signed [15:0] half_sum(input logic signed [15:0] a,
		input logic signed [15:0] b);
		logic signed [16:0] s;
		s = {a[15], a} + {b[15], b};
		return s[16:1];
	endfunction

endpackage

@@ design/rtgf_cfg_if.sv @@
// Configuration write channel of the radar track gate and fuse block.
// Depends on rtgf_pkg for the index width and the gate width.
interface rtgf_cfg_if import rtgf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [GATE_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/rtgf_in_if.sv @@
// Input item channel of the radar track gate and fuse block.
// Depends on nothing but the language itself.
interface rtgf_in_if ();
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] vel_x;
	logic signed [15:0] vel_y;
	logic [7:0]         road_number;
	logic [15:0]        target_id;

	modport source (output valid, operation, pos_x, pos_y, vel_x, vel_y, road_number,
		target_id, input ready);
	modport sink (input valid, operation, pos_x, pos_y, vel_x, vel_y, road_number,
		target_id, output ready);
endinterface

@@ design/rtgf_out_if.sv @@
// Result record channel of the radar track gate and fuse block.
// Depends on nothing but the language itself.
interface rtgf_out_if ();
	logic               valid;
	logic               ready;
	logic               is_match;
	logic [4:0]         entry_index;
	logic signed [15:0] fused_pos_x;
	logic signed [15:0] fused_pos_y;
	logic signed [15:0] fused_vel_x;
	logic signed [15:0] fused_vel_y;
	logic [7:0]         fused_road;
	logic [15:0]        fused_id;
	logic               last;

	modport source (output valid, is_match, entry_index, fused_pos_x, fused_pos_y,
		fused_vel_x, fused_vel_y, fused_road, fused_id, last, input ready);
	modport sink (input valid, is_match, entry_index, fused_pos_x, fused_pos_y,
		fused_vel_x, fused_vel_y, fused_road, fused_id, last, output ready);
endinterface

@@ design/radar_track_gate_fuse.sv @@
// Radar track gate and fuse: gated association of targets against a stored target table.
// Clear and load words are taken in the idle state; an associate word closes the input for the
// walk over the stored entries of the table RAM, its two compute stages and the terminator word,
// plus any result sink stalls.
// Reset clears the entry count and restores the gate registers; the table RAM is not cleared.
// Depends on rtgf_pkg, the three channel interfaces and rtgf_ram.
module radar_track_gate_fuse import rtgf_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	rtgf_cfg_if.sink    cfg,
	rtgf_in_if.sink     item_in,
	rtgf_out_if.source  rec_out
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic                  state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      idx_q;
	logic [GATE_W-1:0]     range_gate_q;
	logic [GATE_W-1:0]     velocity_gate_q;
	logic [GATE_SQ_W-1:0]  rg2_q;
	logic [GATE_SQ_W-1:0]  vg2_q;
	logic signed [15:0]    px_q;
	logic signed [15:0]    py_q;
	logic signed [15:0]    vx_q;
	logic signed [15:0]    vy_q;
	logic [7:0]            road_q;

	logic                  v_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  v_s2;
	logic [IDX_W-1:0]      idx_s2;
	logic [31:0]           sqpx_s2;
	logic [31:0]           sqpy_s2;
	logic [31:0]           sqvx_s2;
	logic [31:0]           sqvy_s2;
	logic                  road_eq_s2;
	entry_t                fused_s2;

	logic                  out_valid_q;
	logic                  is_match_q;
	logic [ENTRY_INDEX_W-1:0] entry_index_q;
	entry_t                out_q;
	logic                  last_q;

	logic                  accept;
	logic                  load_ok;
	logic                  adv;
	logic                  issue;
	logic                  done;
	logic                  match_s2;
	logic [32:0]           dp;
	logic [32:0]           dv;
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	entry_t                ram_wentry;
	logic                  ram_re;
	logic [ENTRY_W-1:0]    ram_rdata;
	entry_t                rd_e;
	entry_t                ld_e;
	logic signed [16:0]    dpx;
	logic signed [16:0]    dpy;
	logic signed [16:0]    dvx;
	logic signed [16:0]    dvy;
	logic signed [33:0]    prod_px;
	logic signed [33:0]    prod_py;
	logic signed [33:0]    prod_vx;
	logic signed [33:0]    prod_vy;

	assign cfg.ready     = 1'b1;
	assign item_in.ready = (state_q == ST_IDLE);
	assign accept        = item_in.valid && item_in.ready;
	assign load_ok       = accept && (item_in.operation == OP_LOAD)
		&& (cnt_q < CNT_W'(TABLE_DEPTH));

	assign adv   = !out_valid_q || rec_out.ready;
	assign issue = (state_q == ST_WALK) && (idx_q != cnt_q);
	assign done  = (state_q == ST_WALK) && !issue && !v_s1 && !v_s2;

	assign ld_e = '{pos_x: item_in.pos_x, pos_y: item_in.pos_y, vel_x: item_in.vel_x,
		vel_y: item_in.vel_y, road: item_in.road_number, id: item_in.target_id};

	assign ram_we     = load_ok || (adv && match_s2);
	assign ram_waddr  = load_ok ? cnt_q[IDX_W-1:0] : idx_s2;
	assign ram_wentry = load_ok ? ld_e : fused_s2;
	assign ram_re     = adv && issue;

	rtgf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wentry),
		.re    (ram_re),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign rd_e = entry_t'(ram_rdata);

	assign dpx = {px_q[15], px_q} - {rd_e.pos_x[15], rd_e.pos_x};
	assign dpy = {py_q[15], py_q} - {rd_e.pos_y[15], rd_e.pos_y};
	assign dvx = {vx_q[15], vx_q} - {rd_e.vel_x[15], rd_e.vel_x};
	assign dvy = {vy_q[15], vy_q} - {rd_e.vel_y[15], rd_e.vel_y};
	assign prod_px = 34'(dpx) * 34'(dpx);
	assign prod_py = 34'(dpy) * 34'(dpy);
	assign prod_vx = 34'(dvx) * 34'(dvx);
	assign prod_vy = 34'(dvy) * 34'(dvy);

	assign dp = {1'b0, sqpx_s2} + {1'b0, sqpy_s2};
	assign dv = {1'b0, sqvx_s2} + {1'b0, sqvy_s2};
	assign match_s2 = v_s2 && road_eq_s2 && (dp <= {1'b0, rg2_q}) && (dv <= {1'b0, vg2_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_gate_q    <= RANGE_GATE_RST;
			velocity_gate_q <= VELOCITY_GATE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_RANGE_GATE: range_gate_q <= cfg.data;
				CFG_VELOCITY_GATE: velocity_gate_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item_in.operation)
							OP_CLEAR: cnt_q <= '0;
							OP_LOAD: begin
								if (load_ok) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							OP_ASSOCIATE: begin
								idx_q   <= '0;
								state_q <= ST_WALK;
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					if (adv) begin
						v_s1 <= issue;
						v_s2 <= v_s1;
						if (issue) begin
							idx_q <= idx_q + CNT_W'(1);
						end
						if (done) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (adv && (match_s2 || done)) begin
				out_valid_q <= 1'b1;
			end else if (rec_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q   <= item_in.pos_x;
			py_q   <= item_in.pos_y;
			vx_q   <= item_in.vel_x;
			vy_q   <= item_in.vel_y;
			road_q <= item_in.road_number;
			rg2_q  <= GATE_SQ_W'(range_gate_q) * GATE_SQ_W'(range_gate_q);
			vg2_q  <= GATE_SQ_W'(velocity_gate_q) * GATE_SQ_W'(velocity_gate_q);
		end
		if (adv) begin
			idx_s1 <= idx_q[IDX_W-1:0];
			idx_s2 <= idx_s1;
			sqpx_s2 <= prod_px[31:0];
			sqpy_s2 <= prod_py[31:0];
			sqvx_s2 <= prod_vx[31:0];
			sqvy_s2 <= prod_vy[31:0];
			road_eq_s2 <= (rd_e.road == road_q);
			fused_s2 <= '{pos_x: half_sum(px_q, rd_e.pos_x), pos_y: half_sum(py_q, rd_e.pos_y),
				vel_x: half_sum(vx_q, rd_e.vel_x), vel_y: half_sum(vy_q, rd_e.vel_y),
				road: rd_e.road, id: rd_e.id};
			if (match_s2) begin
				is_match_q    <= 1'b1;
				entry_index_q <= ENTRY_INDEX_W'(idx_s2);
				out_q         <= fused_s2;
				last_q        <= 1'b0;
			end else if (done) begin
				is_match_q    <= 1'b0;
				entry_index_q <= '0;
				out_q         <= '0;
				last_q        <= 1'b1;
			end
		end
	end

	assign rec_out.valid       = out_valid_q;
	assign rec_out.is_match    = is_match_q;
	assign rec_out.entry_index = entry_index_q;
	assign rec_out.fused_pos_x = out_q.pos_x;
	assign rec_out.fused_pos_y = out_q.pos_y;
	assign rec_out.fused_vel_x = out_q.vel_x;
	assign rec_out.fused_vel_y = out_q.vel_y;
	assign rec_out.fused_road  = out_q.road;
	assign rec_out.fused_id    = out_q.id;
	assign rec_out.last        = last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count exceeds table depth");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (idx_q <= cnt_q))
		else $error("walk index passed entry count");

	a_stages_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> (state_q == ST_WALK))
		else $error("pipeline busy outside a walk");

	a_term_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (!is_match_q && !v_s1 && !v_s2))
		else $error("terminator word issued before the walk drained");

endmodule

@@ design/rtgf_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module rtgf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ bench/radar_track_gate_fuse_tb.sv @@
// Self-checking testbench of radar_track_gate_fuse: a directed table, then random phases
// under several gate settings and idle patterns, checked by a local predictor or fixed records.
// Depends on rtgf_pkg, the three channel interfaces and the design itself.
`timescale 1ns / 100ps

module radar_track_gate_fuse_tb;
	import rtgf_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int SETTLE_CYCLES      = 40;
	localparam int QUIET_LIMIT        = 5000;
	localparam int RANDOM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE    = 50;

	typedef struct packed {
		logic               is_match;
		logic [4:0]         entry_index;
		logic signed [15:0] fused_pos_x;
		logic signed [15:0] fused_pos_y;
		logic signed [15:0] fused_vel_x;
		logic signed [15:0] fused_vel_y;
		logic [7:0]         fused_road;
		logic [15:0]        fused_id;
		logic               last;
	} fused_rec_t;

	typedef struct {
		logic [1:0] op;
		entry_t     tgt;
		bit         fixed;
		int         hit;
	} stim_row_t;

	localparam fused_rec_t TERMINATOR = '{last: 1'b1, default: '0};

	logic clk;
	logic arst_n;

	rtgf_cfg_if cfg_ch ();
	rtgf_in_if  in_ch ();
	rtgf_out_if out_ch ();

	radar_track_gate_fuse i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.item_in (in_ch),
		.rec_out (out_ch)
	);

	entry_t      track_table [TABLE_DEPTH];
	int          track_count;
	logic [15:0] gate_pos;
	logic [15:0] gate_vel;
	fused_rec_t  fused_expected [$];
	stim_row_t   dir_rows [$];

	int send_idle_pct;
	int recv_stall_pct;
	int err_count;
	int rec_count;
	int items_sent;
	int assoc_sent;
	int cfg_writes;

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		$display("MISMATCH %s", msg);
	endtask

	task automatic check_field(input string name, input longint got, input longint want);
		if (got != want) begin
			report_mismatch($sformatf("record %0d field %s: got %0h expected %0h",
				rec_count, name, got, want));
		end
	endtask

	task automatic expect_rec(input fused_rec_t r);
		fused_expected.insert(fused_expected.size(), r);
	endtask

	task automatic add_row(input stim_row_t row);
		dir_rows.insert(dir_rows.size(), row);
	endtask

	function automatic logic signed [15:0] mid16(input logic signed [15:0] a,
		input logic signed [15:0] b);
		int s;
		s = int'(a) + int'(b);
		return 16'(s >>> 1);
	endfunction

	task automatic fuse_predict(input logic [1:0] op, input entry_t t, input bit emit);
		longint unsigned rg2, vg2, dp, dv;
		longint dx, dy, dvx, dvy;
		entry_t e;
		fused_rec_t r;
		case (op)
			OP_CLEAR: begin
				track_count = 0;
			end
			OP_LOAD: begin
				if (track_count < TABLE_DEPTH) begin
					track_table[track_count] = t;
					track_count++;
				end
			end
			OP_ASSOCIATE: begin
				rg2 = gate_pos;
				rg2 = rg2 * rg2;
				vg2 = gate_vel;
				vg2 = vg2 * vg2;
				for (int i = 0; i < track_count; i++) begin
					e = track_table[i];
					if (e.road == t.road) begin
						dx  = $signed(t.pos_x) - $signed(e.pos_x);
						dy  = $signed(t.pos_y) - $signed(e.pos_y);
						dvx = $signed(t.vel_x) - $signed(e.vel_x);
						dvy = $signed(t.vel_y) - $signed(e.vel_y);
						dp  = dx * dx + dy * dy;
						dv  = dvx * dvx + dvy * dvy;
						if (dp <= rg2 && dv <= vg2) begin
							e.pos_x = mid16(t.pos_x, e.pos_x);
							e.pos_y = mid16(t.pos_y, e.pos_y);
							e.vel_x = mid16(t.vel_x, e.vel_x);
							e.vel_y = mid16(t.vel_y, e.vel_y);
							track_table[i] = e;
							r = '{is_match: 1'b1, entry_index: 5'(i), fused_pos_x: e.pos_x,
								fused_pos_y: e.pos_y, fused_vel_x: e.vel_x,
								fused_vel_y: e.vel_y, fused_road: e.road, fused_id: e.id,
								last: 1'b0};
							if (emit) begin
								expect_rec(r);
							end
						end
					end
				end
				if (emit) begin
					expect_rec(TERMINATOR);
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_item(input logic [1:0] op, input entry_t t, input bit emit);
		if ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_ch.valid       <= 1'b1;
		in_ch.operation   <= op;
		in_ch.pos_x       <= t.pos_x;
		in_ch.pos_y       <= t.pos_y;
		in_ch.vel_x       <= t.vel_x;
		in_ch.vel_y       <= t.vel_y;
		in_ch.road_number <= t.road;
		in_ch.target_id   <= t.id;
		do @(posedge clk); while (!in_ch.ready);
		fuse_predict(op, t, emit);
		if (op != OP_UNUSED) begin
			items_sent++;
		end
		if (op == OP_ASSOCIATE) begin
			assoc_sent++;
		end
	endtask

	task automatic set_gates(input logic [15:0] rg, input logic [15:0] vg);
		in_ch.valid <= 1'b0;
		while (fused_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		for (int k = 0; k < 2; k++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= (k == 0) ? CFG_RANGE_GATE : CFG_VELOCITY_GATE;
			cfg_ch.data  <= (k == 0) ? rg : vg;
			do @(posedge clk); while (!cfg_ch.ready);
			if (k == 0) begin
				gate_pos = rg;
			end else begin
				gate_vel = vg;
			end
			cfg_writes++;
		end
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_idle(input int mode);
		case (mode)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct  = 67;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 67;
			end
			default: begin
				send_idle_pct  = 35;
				recv_stall_pct = 35;
			end
		endcase
	endtask

	function automatic stim_row_t mk_row(input logic [1:0] op, input int px, input int py,
		input int vx, input int vy, input int rd, input int id, input bit fixed,
		input int hit);
		stim_row_t row;
		row.op        = op;
		row.tgt.pos_x = 16'(px);
		row.tgt.pos_y = 16'(py);
		row.tgt.vel_x = 16'(vx);
		row.tgt.vel_y = 16'(vy);
		row.tgt.road  = 8'(rd);
		row.tgt.id    = 16'(id);
		row.fixed     = fixed;
		row.hit       = hit;
		return row;
	endfunction

	function automatic entry_t rand_target();
		entry_t t;
		t.pos_x = 16'($urandom);
		t.pos_y = 16'($urandom);
		t.vel_x = 16'($urandom);
		t.vel_y = 16'($urandom);
		t.road  = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(3));
		t.id    = 16'($urandom);
		return t;
	endfunction

	function automatic int jitter(input int unsigned gate);
		int unsigned lim;
		int d;
		lim = ($urandom_range(4) == 0) ? gate : gate / 2;
		d = $urandom_range(lim);
		return $urandom_range(1) ? d : -d;
	endfunction

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Watchdog: no word accepted for %0d cycles", QUIET_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk) begin
		fused_rec_t got;
		fused_rec_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{is_match: out_ch.is_match, entry_index: out_ch.entry_index,
				fused_pos_x: out_ch.fused_pos_x, fused_pos_y: out_ch.fused_pos_y,
				fused_vel_x: out_ch.fused_vel_x, fused_vel_y: out_ch.fused_vel_y,
				fused_road: out_ch.fused_road, fused_id: out_ch.fused_id, last: out_ch.last};
			if (fused_expected.size() == 0) begin
				report_mismatch($sformatf("record %0d arrived with nothing expected",
					rec_count));
			end else begin
				want = fused_expected.pop_front();
				check_field("is_match", got.is_match, want.is_match);
				check_field("entry_index", got.entry_index, want.entry_index);
				check_field("fused_pos_x", got.fused_pos_x, want.fused_pos_x);
				check_field("fused_pos_y", got.fused_pos_y, want.fused_pos_y);
				check_field("fused_vel_x", got.fused_vel_x, want.fused_vel_x);
				check_field("fused_vel_y", got.fused_vel_y, want.fused_vel_y);
				check_field("fused_road", got.fused_road, want.fused_road);
				check_field("fused_id", got.fused_id, want.fused_id);
				check_field("last", got.last, want.last);
			end
			rec_count++;
		end
	end

	initial begin
		stim_row_t row;
		entry_t t;
		entry_t e;
		int start_items;
		int n_load;
		int pick;
		logic [15:0] rg;
		logic [15:0] vg;

		clk               = 1'b0;
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.operation   = OP_CLEAR;
		in_ch.pos_x       = '0;
		in_ch.pos_y       = '0;
		in_ch.vel_x       = '0;
		in_ch.vel_y       = '0;
		in_ch.road_number = '0;
		in_ch.target_id   = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = CFG_RANGE_GATE;
		cfg_ch.data       = '0;
		track_count       = 0;
		gate_pos          = RANGE_GATE_RST;
		gate_vel          = VELOCITY_GATE_RST;
		err_count         = 0;
		rec_count         = 0;
		items_sent        = 0;
		assoc_sent        = 0;
		cfg_writes        = 0;
		set_idle(0);

		add_row(mk_row(OP_ASSOCIATE, 0, 0, 0, 0, 0, 0, 1, -1));
		add_row(mk_row(OP_UNUSED, -1, -1, -1, -1, 255, 65535, 0, -1));
		add_row(mk_row(OP_LOAD, 32767, -32768, 32767, -32768, 255, 65535, 0, -1));
		add_row(mk_row(OP_ASSOCIATE, 32767, -32768, 32767, -32768, 255, 65535,
			1, 0));
		add_row(mk_row(OP_LOAD, -32768, 32767, -32768, 32767, 0, 0, 0, -1));
		add_row(mk_row(OP_ASSOCIATE, -32768, 32767, -32768, 32767, 0, 0, 1, 1));
		add_row(mk_row(OP_LOAD, 100, 100, 10, 10, 7, 'h1234, 0, -1));
		add_row(mk_row(OP_ASSOCIATE, 110, 110, 12, 12, 7, 'h0042, 0, -1));
		add_row(mk_row(OP_ASSOCIATE, 500, -500, 10, 10, 7, 1, 1, -1));
		add_row(mk_row(OP_ASSOCIATE, 105, 105, 300, 11, 7, 2, 1, -1));
		add_row(mk_row(OP_LOAD, 104, 104, 11, 11, 7, 'h4321, 0, -1));
		add_row(mk_row(OP_ASSOCIATE, 104, 104, 11, 11, 7, 3, 0, -1));
		add_row(mk_row(OP_LOAD, 0, 0, 0, 0, 9, 'h0909, 0, -1));
		add_row(mk_row(OP_ASSOCIATE, 32, 0, 64, 0, 9, 4, 0, -1));
		add_row(mk_row(OP_ASSOCIATE, -17, 0, 32, 0, 9, 5, 1, -1));
		add_row(mk_row(OP_ASSOCIATE, 16, 0, 32, 65, 9, 6, 0, -1));
		add_row(mk_row(OP_ASSOCIATE, 32767, -32768, 32767, -32768, 254, 65535,
			1, -1));
		add_row(mk_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, -1));
		add_row(mk_row(OP_ASSOCIATE, 0, 0, 0, 0, 0, 0, 1, -1));
		add_row(mk_row(OP_LOAD, 1, 2, 3, 4, 5, 6, 0, -1));
		add_row(mk_row(OP_ASSOCIATE, 1, 2, 3, 4, 5, 6, 1, 0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[n]) begin
			row = dir_rows[n];
			send_item(row.op, row.tgt, !row.fixed);
			if (row.fixed) begin
				if (row.hit >= 0) begin
					expect_rec('{is_match: 1'b1, entry_index: 5'(row.hit),
						fused_pos_x: row.tgt.pos_x, fused_pos_y: row.tgt.pos_y,
						fused_vel_x: row.tgt.vel_x, fused_vel_y: row.tgt.vel_y,
						fused_road: row.tgt.road, fused_id: row.tgt.id, last: 1'b0});
				end
				expect_rec(TERMINATOR);
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					rg = 16'hFFFF;
					vg = 16'hFFFF;
				end
				1: begin
					rg = 16'h0000;
					vg = 16'h0000;
				end
				2: begin
					rg = 16'h0000;
					vg = 16'hFFFF;
				end
				3: begin
					rg = 16'hFFFF;
					vg = 16'h0000;
				end
				4: begin
					rg = RANGE_GATE_RST;
					vg = VELOCITY_GATE_RST;
				end
				default: begin
					rg = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(16, 4096));
					vg = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(16, 8192));
				end
			endcase
			set_gates(rg, vg);
			set_idle(ph % 4);
			start_items = items_sent;

			if ($urandom_range(3) != 0) begin
				send_item(OP_CLEAR, rand_target(), 1'b1);
			end
			n_load = ($urandom_range(4) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
			repeat (n_load) begin
				send_item(OP_LOAD, rand_target(), 1'b1);
			end

			while (items_sent - start_items < ITEMS_PER_PHASE) begin
				pick = $urandom_range(99);
				if (pick < 70 && track_count > 0) begin
					e = track_table[$urandom_range(track_count - 1)];
					t = e;
					t.pos_x = 16'(int'(e.pos_x) + jitter(gate_pos));
					t.pos_y = 16'(int'(e.pos_y) + jitter(gate_pos));
					t.vel_x = 16'(int'(e.vel_x) + jitter(gate_vel));
					t.vel_y = 16'(int'(e.vel_y) + jitter(gate_vel));
					t.id    = 16'($urandom);
					send_item(OP_ASSOCIATE, t, 1'b1);
				end else if (pick < 88) begin
					send_item(OP_ASSOCIATE, rand_target(), 1'b1);
				end else if (pick < 93) begin
					send_item(OP_LOAD, rand_target(), 1'b1);
				end else if (pick < 96) begin
					send_item(OP_CLEAR, rand_target(), 1'b1);
				end else begin
					send_item(OP_UNUSED, rand_target(), 1'b1);
				end
			end
		end

		in_ch.valid <= 1'b0;
		while (fused_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fused_expected.size() != 0) begin
			report_mismatch($sformatf("%0d expected records never arrived",
				fused_expected.size()));
		end

		$display("Covered %0d input words (%0d associate) and %0d result words", items_sent,
			assoc_sent, rec_count);
		$display("over %0d gate writes, %0d random phases, %0d mismatches", cfg_writes,
			RANDOM_PHASES, err_count);
		if (err_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
